// ===== rtl/core/osdt_pkg.sv =====
`default_nettype none
package osdt_pkg;

  localparam int NUM_CHANNELS_DEF = 8;
  localparam int DELAY_BITS_DEF   = 16;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_ARM    = 2'd1;
  localparam logic [1:0] OP_CANCEL = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [2:0]  channel;
    logic [15:0] delay_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  fired_channel;
    logic [31:0] time_ms;
    logic        last_of_run;
  } out_item_t;

  // broadcast to every cell for one accepted transaction
  typedef struct packed {
    logic        tick;
    logic        arm;
    logic        cancel;
    logic [2:0]  channel;
    logic [15:0] delay_ms;
  } cell_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/osdt_cell.sv =====
`default_nettype none
module osdt_cell #(
  parameter int INDEX      = 0,
  parameter int DELAY_BITS = osdt_pkg::DELAY_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  osdt_pkg::cell_cmd_t cmd,
  input  wire                 tok_in,
  input  wire                 advance,
  input  wire                 emit_ok,
  output logic                tok_out,
  output logic                pend
);

  localparam logic [32:0] DELAY_MAX = (33'd1 << DELAY_BITS) - 33'd1;

  logic                  armed_r, armed_nxt;
  logic                  pend_r, pend_nxt;
  logic                  tok_r, tok_nxt;
  logic [DELAY_BITS-1:0] remain_r, remain_nxt;
  logic [DELAY_BITS-1:0] load_val;
  logic                  hit;

  assign hit = (32'(cmd.channel) == INDEX);
  assign load_val = (33'(cmd.delay_ms) > DELAY_MAX) ? '1 : DELAY_BITS'(cmd.delay_ms);

  always_comb begin
    armed_nxt  = armed_r;
    pend_nxt   = pend_r;
    remain_nxt = remain_r;
    tok_nxt    = tok_r;
    if (cmd.tick || advance) begin
      tok_nxt = tok_in;
    end
    if (cmd.arm && hit) begin
      armed_nxt  = 1'b1;
      remain_nxt = load_val;
    end else if (cmd.cancel && hit) begin
      armed_nxt = 1'b0;
    end else if (cmd.tick && armed_r) begin
      if (remain_r == '0) begin
        armed_nxt = 1'b0;
        pend_nxt  = 1'b1;
      end else begin
        remain_nxt = remain_r - 1'b1;
      end
    end
    if (tok_r && pend_r && emit_ok) begin
      pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r  <= 1'b0;
      pend_r   <= 1'b0;
      tok_r    <= 1'b0;
      remain_r <= '0;
    end else begin
      armed_r  <= armed_nxt;
      pend_r   <= pend_nxt;
      tok_r    <= tok_nxt;
      remain_r <= remain_nxt;
    end
  end

  assign tok_out = tok_r;
  assign pend    = pend_r;

endmodule
`default_nettype wire

// ===== rtl/core/oneshot_delay_timer_bank.sv =====
// Bank of one-shot millisecond delay channels built as a row of channel cells.
// Arm and cancel transactions never stall the input. A tick transaction updates
// every cell at once, then a scan token walks the row one cell per cycle unless
// a fired cell waits on a stalled output, and each expired channel emits one
// event in index order, the last one marked. While any fired channel is still
// waiting to be reported the input is stalled; a tick that fires nothing never
// stalls it.
`default_nettype none
module oneshot_delay_timer_bank #(
  parameter int NUM_CHANNELS = osdt_pkg::NUM_CHANNELS_DEF,
  parameter int DELAY_BITS   = osdt_pkg::DELAY_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  osdt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output osdt_pkg::out_item_t out_data
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  osdt_pkg::cell_cmd_t     cmd;
  logic [NUM_CHANNELS-1:0] tok_vec;
  logic [NUM_CHANNELS-1:0] pend_vec;
  logic                    in_acc, busy, hit, slot_free, advance, emit, last;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [31:0]             millis_r, millis_nxt;
  logic                    out_valid_r, out_valid_nxt;
  osdt_pkg::out_item_t     out_data_r, out_data_nxt;

  assign busy     = |pend_vec;
  assign in_stall = busy;
  assign in_acc   = in_valid && !busy;

  assign cmd.tick     = in_acc && (in_data.operation == osdt_pkg::OP_TICK);
  assign cmd.arm      = in_acc && (in_data.operation == osdt_pkg::OP_ARM);
  assign cmd.cancel   = in_acc && (in_data.operation == osdt_pkg::OP_CANCEL);
  assign cmd.channel  = in_data.channel;
  assign cmd.delay_ms = in_data.delay_ms;

  assign hit       = |(tok_vec & pend_vec);
  assign slot_free = !out_valid_r || !out_stall;
  assign advance   = !hit || slot_free;
  assign emit      = hit && slot_free;
  // lower pending cells are already reported, so one left means last
  assign last      = ((pend_vec & (pend_vec - 1'b1)) == '0);

  genvar g;
  generate
    for (g = 0; g < NUM_CHANNELS; g++) begin : g_cell
      logic tok_feed;
      if (g == 0) begin : g_first
        assign tok_feed = cmd.tick;
      end else begin : g_rest
        assign tok_feed = tok_vec[g-1] && !cmd.tick;
      end
      osdt_cell #(
        .INDEX      (g),
        .DELAY_BITS (DELAY_BITS)
      ) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .tok_in  (tok_feed),
        .advance (advance),
        .emit_ok (slot_free),
        .tok_out (tok_vec[g]),
        .pend    (pend_vec[g])
      );
    end
  endgenerate

  always_comb begin
    idx_nxt       = idx_r;
    millis_nxt    = millis_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (cmd.tick) begin
      idx_nxt    = '0;
      millis_nxt = millis_r + 32'd1;
    end else if (busy && advance) begin
      idx_nxt = idx_r + 1'b1;
    end
    if (emit) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.fired_channel = 3'(idx_r);
      out_data_nxt.time_ms       = millis_r;
      out_data_nxt.last_of_run   = last;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      millis_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      millis_r    <= millis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== rtl/core/osdt_checker.sv =====
`default_nettype none
module osdt_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input wire                 in_stall,
  input osdt_pkg::in_item_t  in_data,
  input wire                 out_valid,
  input wire                 out_stall,
  input osdt_pkg::out_item_t out_data
);

  // stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("output changed while stalled");

  // arm or cancel never starts a report scan
  a_cfg_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.operation != osdt_pkg::OP_TICK) |=> !in_stall)
    else $error("stall after arm or cancel");

  // more events of the run still owed
  a_run_open: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last_of_run) |-> in_stall)
    else $error("input open with run incomplete");

endmodule

bind oneshot_delay_timer_bank osdt_checker u_osdt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

// ===== dv/oneshot_delay_timer_bank_tb.sv =====
`timescale 1ns / 1ps
module oneshot_delay_timer_bank_tb;

  localparam int NUM_CH = osdt_pkg::NUM_CHANNELS_DEF;
  localparam int DLY_W = osdt_pkg::DELAY_BITS_DEF;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned RANDOM_PER_CHUNK = 46;

  class timer_scoreboard;
    logic [DLY_W-1:0] remaining[NUM_CH];
    bit armed[NUM_CH];
    logic [31:0] millis;
    osdt_pkg::out_item_t due_events[$];
    int unsigned errors;

    function new();
      foreach (armed[i]) begin
        armed[i] = 1'b0;
        remaining[i] = '0;
      end
      millis = '0;
      errors = 0;
    endfunction

    function int pending();
      return due_events.size();
    endfunction

    // update the channel state for one accepted transaction
    function void apply_command(osdt_pkg::in_item_t it);
      osdt_pkg::out_item_t ev;
      int last_idx;
      last_idx = -1;
      case (it.operation)
        osdt_pkg::OP_ARM: begin
          if (it.channel < NUM_CH) begin
            if (it.delay_ms > {DLY_W{1'b1}}) remaining[it.channel] = {DLY_W{1'b1}};
            else remaining[it.channel] = DLY_W'(it.delay_ms);
            armed[it.channel] = 1'b1;
          end
        end
        osdt_pkg::OP_CANCEL: begin
          if (it.channel < NUM_CH) armed[it.channel] = 1'b0;
        end
        osdt_pkg::OP_TICK: begin
          millis = millis + 32'd1;
          for (int i = 0; i < NUM_CH; i++) begin
            if (armed[i] && remaining[i] == '0) last_idx = i;
          end
          for (int i = 0; i < NUM_CH; i++) begin
            if (armed[i]) begin
              if (remaining[i] == '0) begin
                ev.fired_channel = 3'(i);
                ev.time_ms = millis;
                ev.last_of_run = (i == last_idx);
                due_events.push_back(ev);
                armed[i] = 1'b0;
              end else begin
                remaining[i] = remaining[i] - 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_event(osdt_pkg::out_item_t got);
      osdt_pkg::out_item_t want;
      if (due_events.size() == 0) begin
        $error("unexpected event: fired_channel %0d time_ms %0d last_of_run %0b",
               got.fired_channel, got.time_ms, got.last_of_run);
        errors++;
        return;
      end
      want = due_events.pop_front();
      if (got.fired_channel !== want.fired_channel) begin
        $error("fired_channel: expected %0d, actual %0d", want.fired_channel,
               got.fired_channel);
        errors++;
      end
      if (got.time_ms !== want.time_ms) begin
        $error("time_ms: expected %0d, actual %0d", want.time_ms, got.time_ms);
        errors++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $error("last_of_run: expected %0b, actual %0b", want.last_of_run,
               got.last_of_run);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  osdt_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  osdt_pkg::out_item_t out_data;
  logic hold_phase = 1'b0;

  timer_scoreboard sb = new();

  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  int unsigned flow_left = 0;
  bit hold_taken = 1'b0;

  oneshot_delay_timer_bank i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #2 clk = ~clk;

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int unsigned rand_delay();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(0, 6);
    if (r < 93) return $urandom_range(7, 60);
    return $urandom_range(0, 65535);
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // transaction monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.apply_command(in_data);
      if (out_valid && !out_stall) sb.check_event(out_data);
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (hold_phase && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = LONG_HOLD;
    end else if (!hold_phase) begin
      hold_taken = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (flow_left != 0) begin
      flow_left--;
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b0;
      flow_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 3);
      stall_left = idle_len();
    end
  end

  task automatic send_item(input logic [1:0] op, input int unsigned ch,
                           input int unsigned dly, input int unsigned gap);
    osdt_pkg::in_item_t it;
    it.operation = op;
    it.channel = 3'(ch);
    it.delay_ms = 16'(dly);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_random(input int unsigned gap);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      send_item(osdt_pkg::OP_TICK, $urandom_range(0, 7), $urandom_range(0, 65535), gap);
    end else if (r < 80) begin
      send_item(osdt_pkg::OP_ARM, $urandom_range(0, 7), rand_delay(), gap);
    end else if (r < 96) begin
      send_item(osdt_pkg::OP_CANCEL, $urandom_range(0, 7), $urandom_range(0, 65535), gap);
    end else begin
      send_item(OP_UNUSED, $urandom_range(0, 7), $urandom_range(0, 65535), gap);
    end
  endtask

  initial begin
    bit steady;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    send_item(osdt_pkg::OP_TICK, 7, 16'hFFFF, 0);
    send_item(osdt_pkg::OP_CANCEL, 3, 0, idle_len());
    send_item(osdt_pkg::OP_ARM, 0, 0, 0);
    send_item(osdt_pkg::OP_ARM, 7, 16'hFFFF, idle_len());
    send_item(osdt_pkg::OP_ARM, 7, 1, 0);
    send_item(osdt_pkg::OP_ARM, 5, 16'h5555, 0);
    send_item(osdt_pkg::OP_ARM, 3, 2, idle_len());
    send_item(osdt_pkg::OP_CANCEL, 3, 16'hAAAA, 0);
    send_item(OP_UNUSED, 6, 16'hAAAA, 0);
    send_item(osdt_pkg::OP_TICK, 0, 0, idle_len());
    send_item(osdt_pkg::OP_TICK, 0, 0, 0);
    send_item(osdt_pkg::OP_CANCEL, 5, 0, 0);
    send_item(osdt_pkg::OP_TICK, 0, 0, idle_len());
    for (int i = 0; i < NUM_CH; i++) send_item(osdt_pkg::OP_ARM, i, 0, 0);
    send_item(osdt_pkg::OP_TICK, 0, 0, 0);
    send_item(osdt_pkg::OP_TICK, 0, 0, 0);
    wait_drained();

    // receiver holds off while the sender keeps offering
    hold_phase <= 1'b1;
    for (int i = 0; i < NUM_CH; i++) send_item(osdt_pkg::OP_ARM, i, i % 2, 0);
    for (int i = 0; i < 6; i++) begin
      send_item(osdt_pkg::OP_TICK, 0, 0, 0);
      send_item(osdt_pkg::OP_ARM, $urandom_range(0, 7), 0, 0);
    end
    wait_drained();
    hold_phase <= 1'b0;

    // random
    for (int chunk = 0; chunk < 3; chunk++) begin
      steady = (chunk == 1);
      for (int n = 0; n < RANDOM_PER_CHUNK; n++) send_random(steady ? 0 : idle_len());
      wait_drained();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
